@@ hw/rtl/htsp_pkg.sv @@
// Shared types and constants for the Huffman table segment parser.
package htsp_pkg;

    // Result kind codes
    localparam logic [2:0] KIND_IGNORED = 3'd0;
    localparam logic [2:0] KIND_LENGTH  = 3'd1;
    localparam logic [2:0] KIND_HEADER  = 3'd2;
    localparam logic [2:0] KIND_COUNT   = 3'd3;
    localparam logic [2:0] KIND_SYMBOL  = 3'd4;

    // Index of the last of the sixteen code-length counts
    localparam logic [3:0] LAST_COUNT_INDEX = 4'hF;

    // Length of a segment that holds no table data; smaller lengths are format errors
    localparam logic [15:0] EMPTY_LENGTH = 16'd2;

    // One payload byte of the segment
    typedef struct packed {
        logic [7:0] data_byte;
        logic       seg_start;
    } in_t;

    // One tagged parse result
    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  table_class;
        logic [3:0]  table_id;
        logic [11:0] position;
        logic [7:0]  byte_value;
        logic [11:0] symbol_total;
        logic [15:0] segment_length;
        logic        table_done;
        logic        segment_done;
        logic        format_error;
    } out_t;

endpackage

@@ hw/rtl/htsp_step.sv @@
// Parser state and the per-byte next-state and result logic.
module htsp_step
    import htsp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic take,
    input  in_t  req,
    output out_t res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN_LO,
        PH_HEADER,
        PH_COUNTS,
        PH_SYMBOLS
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] length_reg, length_next;
    logic [3:0]  count_index_reg, count_index_next;
    logic [11:0] count_sum_reg, count_sum_next;
    logic [11:0] symbols_seen_reg, symbols_seen_next;
    logic [3:0]  cur_class_reg, cur_class_next;
    logic [3:0]  cur_id_reg, cur_id_next;

    logic [15:0] bytes_dec;
    logic [11:0] sum_add;
    logic [11:0] seen_inc;
    logic [15:0] len_lo;

    assign bytes_dec = bytes_left_reg - 16'd1;
    assign sum_add   = count_sum_reg + {4'b0, req.data_byte};
    assign seen_inc  = symbols_seen_reg + 12'd1;
    assign len_lo    = {length_reg[15:8], req.data_byte};

    // Next state and result for the byte at the input
    always_comb
    begin
        phase_next        = phase_reg;
        bytes_left_next   = bytes_left_reg;
        length_next       = length_reg;
        count_index_next  = count_index_reg;
        count_sum_next    = count_sum_reg;
        symbols_seen_next = symbols_seen_reg;
        cur_class_next    = cur_class_reg;
        cur_id_next       = cur_id_reg;
        res               = '0;

        if (req.seg_start)
        begin
            // start always restarts, dropping any segment in progress
            length_next = {req.data_byte, 8'h00};
            res.kind    = KIND_LENGTH;
            phase_next  = PH_LEN_LO;
        end
        else
        begin
            case (phase_reg)
                PH_LEN_LO:
                begin
                    length_next        = len_lo;
                    res.kind           = KIND_LENGTH;
                    res.segment_length = len_lo;
                    if (len_lo < EMPTY_LENGTH)
                    begin
                        res.segment_done = 1'b1;
                        res.format_error = 1'b1;
                        phase_next       = PH_IDLE;
                    end
                    else if (len_lo == EMPTY_LENGTH)
                    begin
                        res.segment_done = 1'b1;
                        phase_next       = PH_IDLE;
                    end
                    else
                    begin
                        bytes_left_next = len_lo - EMPTY_LENGTH;
                        phase_next      = PH_HEADER;
                    end
                end
                PH_HEADER:
                begin
                    cur_class_next     = req.data_byte[7:4];
                    cur_id_next        = req.data_byte[3:0];
                    count_index_next   = '0;
                    count_sum_next     = '0;
                    symbols_seen_next  = '0;
                    bytes_left_next    = bytes_dec;
                    res.kind           = KIND_HEADER;
                    res.table_class    = req.data_byte[7:4];
                    res.table_id       = req.data_byte[3:0];
                    res.segment_length = length_reg;
                    if (bytes_dec == '0)
                    begin
                        res.segment_done = 1'b1;
                        res.format_error = 1'b1;
                        phase_next       = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_COUNTS;
                    end
                end
                PH_COUNTS:
                begin
                    count_sum_next     = sum_add;
                    bytes_left_next    = bytes_dec;
                    res.kind           = KIND_COUNT;
                    res.table_class    = cur_class_reg;
                    res.table_id       = cur_id_reg;
                    res.position       = {8'b0, count_index_reg};
                    res.byte_value     = req.data_byte;
                    res.symbol_total   = sum_add;
                    res.segment_length = length_reg;
                    if (count_index_reg == LAST_COUNT_INDEX)
                    begin
                        if (sum_add == '0)
                        begin
                            // table with no symbols ends on its last count
                            res.table_done = 1'b1;
                            if (bytes_dec == '0)
                            begin
                                res.segment_done = 1'b1;
                                phase_next       = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_HEADER;
                            end
                        end
                        else if (bytes_dec == '0)
                        begin
                            res.segment_done = 1'b1;
                            res.format_error = 1'b1;
                            phase_next       = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_SYMBOLS;
                        end
                    end
                    else
                    begin
                        count_index_next = count_index_reg + 4'd1;
                        if (bytes_dec == '0)
                        begin
                            res.segment_done = 1'b1;
                            res.format_error = 1'b1;
                            phase_next       = PH_IDLE;
                        end
                    end
                end
                PH_SYMBOLS:
                begin
                    bytes_left_next    = bytes_dec;
                    symbols_seen_next  = seen_inc;
                    res.kind           = KIND_SYMBOL;
                    res.table_class    = cur_class_reg;
                    res.table_id       = cur_id_reg;
                    res.position       = symbols_seen_reg;
                    res.byte_value     = req.data_byte;
                    res.symbol_total   = count_sum_reg;
                    res.segment_length = length_reg;
                    if (seen_inc == count_sum_reg)
                    begin
                        res.table_done = 1'b1;
                        if (bytes_dec == '0)
                        begin
                            res.segment_done = 1'b1;
                            phase_next       = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                    else if (bytes_dec == '0)
                    begin
                        res.segment_done = 1'b1;
                        res.format_error = 1'b1;
                        phase_next       = PH_IDLE;
                    end
                end
                default:
                begin
                    // byte outside a segment: ignored, all-zero result
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // State update on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bytes_left_reg   <= '0;
            length_reg       <= '0;
            count_index_reg  <= '0;
            count_sum_reg    <= '0;
            symbols_seen_reg <= '0;
            cur_class_reg    <= '0;
            cur_id_reg       <= '0;
        end
        else if (take)
        begin
            phase_reg        <= phase_next;
            bytes_left_reg   <= bytes_left_next;
            length_reg       <= length_next;
            count_index_reg  <= count_index_next;
            count_sum_reg    <= count_sum_next;
            symbols_seen_reg <= symbols_seen_next;
            cur_class_reg    <= cur_class_next;
            cur_id_reg       <= cur_id_next;
        end
    end

endmodule

@@ hw/rtl/htsp_out_reg.sv @@
// Result register with valid/ready handshake and input back-pressure.
module htsp_out_reg
    import htsp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  out_t load_data,
    output logic space,
    output logic result_valid,
    input  logic result_ready,
    output out_t result
);

    logic valid_reg, valid_next;
    out_t data_reg;

    // room for a new result when empty or when the held one leaves now
    assign space        = !valid_reg || result_ready;
    assign valid_next   = load || (valid_reg && !result_ready);
    assign result_valid = valid_reg;
    assign result       = data_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

@@ hw/rtl/huffman_table_segment_parser.sv @@
// Top level of the define-Huffman-table segment parser.
//
//  channel   signals                                   request
//  input     byte_valid / byte_ready / byte_req         one segment payload byte
//  output    result_valid / result_ready / result       one tagged result per byte
//
//  One byte per clock while the output is not stalled: each accepted byte updates
//  the parser state and loads its result into the output register in the same cycle.
//  Reset leaves the parser idle with an empty output register.
//  byte_ready is high whenever the output register is empty or its result is
//  being taken, so a stalled output holds only one result and stops the input.
module huffman_table_segment_parser
    import htsp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic byte_valid,
    output logic byte_ready,
    input  in_t  byte_req,
    output logic result_valid,
    input  logic result_ready,
    output out_t result
);

    logic take;
    logic space;
    out_t step_res;

    assign byte_ready = space;
    assign take       = byte_valid && space;

    // Per-byte parser
    htsp_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .req   (byte_req),
        .res   (step_res)
    );

    // Result register
    htsp_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (take),
        .load_data    (step_res),
        .space        (space),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
